@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the ohmmeter checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on i_clk, quiet during reset
`define ASSERT_SAME(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, sampled on i_clk, quiet during reset
`define ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ src/aro_pkg.sv @@
// ----------------------------------------------------------------------------
// aro_pkg
// shared widths, register codes, reference resistor table and types
// ----------------------------------------------------------------------------
package aro_pkg;

    // field and datapath widths
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned THR_W    = 15;
    localparam int unsigned GAIN_W   = 17;
    localparam int unsigned MPLR_W   = 15;   // 32768 - raw for positive raw
    localparam int unsigned REF_W    = 20;   // up to 1M ohm
    localparam int unsigned P1_W     = MPLR_W + GAIN_W;
    localparam int unsigned PROD_W   = P1_W + REF_W;
    localparam int unsigned DIVD_W   = 36;   // (num + raw*2^15) >> 16
    localparam int unsigned DIVR_W   = 15;
    localparam int unsigned RES_W    = 32;
    localparam int unsigned OVF_BITS = DIVD_W - RES_W;

    // register indexes on the config port
    localparam logic [2:0] REG_LOW_THR  = 3'd0;
    localparam logic [2:0] REG_HIGH_THR = 3'd1;
    localparam logic [2:0] REG_GAIN0    = 3'd2;
    localparam logic [2:0] REG_GAIN1    = 3'd3;
    localparam logic [2:0] REG_GAIN2    = 3'd4;
    localparam logic [2:0] REG_GAIN3    = 3'd5;

    // reset values
    localparam logic [THR_W-1:0]  RST_LOW_THR  = 15'd8000;
    localparam logic [THR_W-1:0]  RST_HIGH_THR = 15'd24000;
    localparam logic [GAIN_W-1:0] RST_GAIN0    = 17'd64618;
    localparam logic [GAIN_W-1:0] RST_GAIN1    = 17'd63898;
    localparam logic [GAIN_W-1:0] RST_GAIN2    = 17'd65536;
    localparam logic [GAIN_W-1:0] RST_GAIN3    = 17'd43778;

    // result of the serial divider
    typedef struct packed {
        logic             done;
        logic             ovf;
        logic [RES_W-1:0] quot;
    } t_div_res;

    // decade reference resistor per range
    function automatic logic [REF_W-1:0] ref_ohms(input logic [1:0] rng);
        logic [REF_W-1:0] v;
        unique case (rng)
            2'd0:    v = 20'd1000;
            2'd1:    v = 20'd10000;
            2'd2:    v = 20'd100000;
            default: v = 20'd1000000;
        endcase
        return v;
    endfunction

endpackage

@@ src/aro_mul.sv @@
// ----------------------------------------------------------------------------
// aro_mul
// bit-serial shift-add multiplier: (32768 - raw) * gain, then * reference
// ----------------------------------------------------------------------------
module aro_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [aro_pkg::MPLR_W-1:0]  i_mplr,
    input  logic [aro_pkg::GAIN_W-1:0]  i_gain,
    input  logic [1:0]                  i_range,
    output logic                        o_done,
    output logic [aro_pkg::PROD_W-1:0]  o_prod
);

    typedef enum logic [2:0] {
        M_IDLE = 3'b001,
        M_GAIN = 3'b010,
        M_REF  = 3'b100
    } t_mstate;

    localparam logic [4:0] GAIN_LAST = 5'(aro_pkg::MPLR_W - 1);
    localparam logic [4:0] REF_LAST  = 5'(aro_pkg::REF_W - 1);

    t_mstate                     r_state;
    logic [4:0]                  r_cnt;
    logic                        r_done;
    logic [aro_pkg::REF_W-1:0]   r_mplr;
    logic [aro_pkg::P1_W-1:0]    r_p1;
    logic [aro_pkg::PROD_W-1:0]  r_acc;
    logic [aro_pkg::GAIN_W:0]    sum_p1;
    logic [aro_pkg::P1_W:0]      sum_acc;

    // narrow adders on the upper part of each accumulator
    assign sum_p1  = {1'b0, r_p1[aro_pkg::P1_W-1:aro_pkg::MPLR_W]} + {1'b0, i_gain};
    assign sum_acc = {1'b0, r_acc[aro_pkg::PROD_W-1:aro_pkg::REF_W]} + {1'b0, r_p1};

    // sequencer: gain pass, then reference pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_state <= M_GAIN;
                        r_cnt   <= '0;
                    end
                end
                M_GAIN: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == GAIN_LAST) begin
                        r_state <= M_REF;
                        r_cnt   <= '0;
                    end
                end
                M_REF: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == REF_LAST) begin
                        r_state <= M_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

    // datapath: multiplier bits shift out lsb first, products shift right
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            M_IDLE: begin
                if (i_start) begin
                    r_mplr <= {{(aro_pkg::REF_W - aro_pkg::MPLR_W){1'b0}}, i_mplr};
                    r_p1   <= '0;
                end
            end
            M_GAIN: begin
                if (r_mplr[0]) begin
                    r_p1 <= {sum_p1, r_p1[aro_pkg::MPLR_W-1:1]};
                end else begin
                    r_p1 <= {1'b0, r_p1[aro_pkg::P1_W-1:1]};
                end
                if (r_cnt == GAIN_LAST) begin
                    r_mplr <= aro_pkg::ref_ohms(i_range);
                    r_acc  <= '0;
                end else begin
                    r_mplr <= {1'b0, r_mplr[aro_pkg::REF_W-1:1]};
                end
            end
            M_REF: begin
                if (r_mplr[0]) begin
                    r_acc <= {sum_acc, r_acc[aro_pkg::REF_W-1:1]};
                end else begin
                    r_acc <= {1'b0, r_acc[aro_pkg::PROD_W-1:1]};
                end
                r_mplr <= {1'b0, r_mplr[aro_pkg::REF_W-1:1]};
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

@@ src/aro_div.sv @@
// ----------------------------------------------------------------------------
// aro_div
// restoring divider, one quotient bit per cycle, flags quotients past 32 bits
// ----------------------------------------------------------------------------
module aro_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [aro_pkg::DIVD_W-1:0]  i_dividend,
    input  logic [aro_pkg::DIVR_W-1:0]  i_divisor,
    output aro_pkg::t_div_res           o_res
);

    localparam logic [5:0] LAST_STEP = 6'(aro_pkg::DIVD_W - 1);
    localparam logic [5:0] OVF_STEPS = 6'(aro_pkg::OVF_BITS);

    logic                        r_busy;
    logic                        r_done;
    logic [5:0]                  r_cnt;
    logic                        r_ovf;
    logic [aro_pkg::DIVD_W-1:0]  r_num;
    logic [aro_pkg::DIVR_W-1:0]  r_rem;
    logic [aro_pkg::DIVR_W-1:0]  r_div;
    logic [aro_pkg::DIVR_W:0]    trial;
    logic [aro_pkg::DIVR_W:0]    diff;
    logic                        q_bit;

    // partial remainder with the next dividend bit, trial subtract
    assign trial = {r_rem, r_num[aro_pkg::DIVD_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign q_bit = (trial >= {1'b0, r_div});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy) begin
                if (i_start) begin
                    r_busy <= 1'b1;
                    r_cnt  <= '0;
                end
            end else begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: quotient bits shift into the dividend register
    always_ff @(posedge i_clk) begin
        if (!r_busy) begin
            if (i_start) begin
                r_num <= i_dividend;
                r_rem <= '0;
                r_div <= i_divisor;
                r_ovf <= 1'b0;
            end
        end else begin
            r_num <= {r_num[aro_pkg::DIVD_W-2:0], q_bit};
            r_rem <= q_bit ? diff[aro_pkg::DIVR_W-1:0] : trial[aro_pkg::DIVR_W-1:0];
            if (q_bit && (r_cnt < OVF_STEPS)) begin
                r_ovf <= 1'b1;
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.ovf  = r_ovf;
    assign o_res.quot = r_num[aro_pkg::RES_W-1:0];

endmodule

@@ src/autorange_ohmmeter.sv @@
// ----------------------------------------------------------------------------
// autorange_ohmmeter
// auto-ranging ohmmeter: range control and resistance from one adc sample
// ----------------------------------------------------------------------------
//  channel   dir  handshake               payload
//  s_axis    in   tvalid/tready           tdata[15:0] adc_sample
//  m_axis    out  tvalid/tready           tdata: range, next select, ohms
//                                         tuser: settled, open_flag
//  apb       in   psel/penable/pwrite     six registers at 4*i
//
//  a range step or a nonpositive settle goes from the eval state straight to
//  the output state; a settled positive sample first takes 15 + 20 multiplier
//  steps and 36 divider steps.
//  one sample is in work at a time; a new request is taken once the result is
//  in the output register, even while that register still waits.
//  reset puts the range at the 1k resistor and loads the register defaults.
// ----------------------------------------------------------------------------
module autorange_ohmmeter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // sample stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [15:0] adc_sample
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [1:0] range_used, [5:2] next_range_select,
                                          // [37:6] resistance_ohms, [39:38] zero
    output logic [1:0]  o_m_axis_tuser,   // [0] settled, [1] open_flag
    // register port
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [4:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EVAL = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state                          r_state;
    t_state                          n_state;

    // registers
    logic [aro_pkg::THR_W-1:0]       r_low_thr;
    logic [aro_pkg::THR_W-1:0]       r_high_thr;
    logic [aro_pkg::GAIN_W-1:0]      r_gain [4];
    logic [1:0]                      r_range;
    logic [1:0]                      n_range;

    // sample and staged result
    logic [aro_pkg::SAMPLE_W-1:0]    r_sample;
    logic                            r_settled;
    logic [1:0]                      r_used;
    logic [aro_pkg::RES_W-1:0]       r_res;
    logic                            r_open;

    // output register
    logic                            r_o_valid;
    logic                            r_o_settled;
    logic [1:0]                      r_o_used;
    logic [3:0]                      r_o_next;
    logic [aro_pkg::RES_W-1:0]       r_o_res;
    logic                            r_o_open;

    // decision and datapath signals
    logic                            is_low;
    logic                            is_high;
    logic                            settle;
    logic                            nonpos;
    logic                            cfg_wr;
    logic [2:0]                      cfg_idx;
    logic                            mul_start;
    logic                            mul_done;
    logic [aro_pkg::PROD_W-1:0]      mul_prod;
    logic [aro_pkg::MPLR_W-1:0]      mul_a;
    logic [aro_pkg::PROD_W:0]        num_rnd;
    logic                            div_start;
    aro_pkg::t_div_res               div_res;
    logic                            out_load;

    // register port
    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel & i_penable & i_pwrite & o_pready;
    assign cfg_idx  = i_paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_thr  <= aro_pkg::RST_LOW_THR;
            r_high_thr <= aro_pkg::RST_HIGH_THR;
            r_gain[0]  <= aro_pkg::RST_GAIN0;
            r_gain[1]  <= aro_pkg::RST_GAIN1;
            r_gain[2]  <= aro_pkg::RST_GAIN2;
            r_gain[3]  <= aro_pkg::RST_GAIN3;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                aro_pkg::REG_LOW_THR:  r_low_thr  <= i_pwdata[aro_pkg::THR_W-1:0];
                aro_pkg::REG_HIGH_THR: r_high_thr <= i_pwdata[aro_pkg::THR_W-1:0];
                aro_pkg::REG_GAIN0:    r_gain[0]  <= i_pwdata[aro_pkg::GAIN_W-1:0];
                aro_pkg::REG_GAIN1:    r_gain[1]  <= i_pwdata[aro_pkg::GAIN_W-1:0];
                aro_pkg::REG_GAIN2:    r_gain[2]  <= i_pwdata[aro_pkg::GAIN_W-1:0];
                aro_pkg::REG_GAIN3:    r_gain[3]  <= i_pwdata[aro_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (cfg_idx)
            aro_pkg::REG_LOW_THR:  o_prdata = 32'(r_low_thr);
            aro_pkg::REG_HIGH_THR: o_prdata = 32'(r_high_thr);
            aro_pkg::REG_GAIN0:    o_prdata = 32'(r_gain[0]);
            aro_pkg::REG_GAIN1:    o_prdata = 32'(r_gain[1]);
            aro_pkg::REG_GAIN2:    o_prdata = 32'(r_gain[2]);
            aro_pkg::REG_GAIN3:    o_prdata = 32'(r_gain[3]);
            default:               o_prdata = '0;
        endcase
    end

    // window test and range step
    assign is_low  = $signed(r_sample) <= $signed({1'b0, r_low_thr});
    assign is_high = $signed(r_sample) >= $signed({1'b0, r_high_thr});
    assign settle  = (!is_low && !is_high) || (is_low && (r_range == 2'd3))
                   || (is_high && (r_range == 2'd0));
    assign nonpos  = r_sample[aro_pkg::SAMPLE_W-1] || (r_sample == '0);

    always_comb begin
        if (settle) begin
            n_range = r_range;
        end else if (is_low) begin
            n_range = r_range + 2'd1;
        end else begin
            n_range = r_range - 2'd1;
        end
    end

    // 32768 - raw, raw known positive here
    assign mul_a     = aro_pkg::MPLR_W'(0) - r_sample[aro_pkg::MPLR_W-1:0];
    assign mul_start = (r_state == S_EVAL) && settle && !nonpos;

    aro_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_mplr  (mul_a),
        .i_gain  (r_gain[r_range]),
        .i_range (r_range),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    // add half the divisor for rounding, then drop the 2^16 of the divisor
    assign num_rnd   = {1'b0, mul_prod}
                     + (aro_pkg::PROD_W + 1)'({r_sample[aro_pkg::MPLR_W-1:0], 15'd0});
    assign div_start = (r_state == S_MUL) && mul_done;

    aro_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (num_rnd[aro_pkg::DIVD_W+15:16]),
        .i_divisor  (r_sample[aro_pkg::DIVR_W-1:0]),
        .o_res      (div_res)
    );

    // sequencer
    assign out_load = (r_state == S_OUT) && (!r_o_valid || i_m_axis_tready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_s_axis_tvalid) n_state = S_EVAL;
            S_EVAL: n_state = mul_start ? S_MUL : S_OUT;
            S_MUL:  if (mul_done) n_state = S_DIV;
            S_DIV:  if (div_res.done) n_state = S_OUT;
            S_OUT:  if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_range <= 2'd0;
        end else begin
            r_state <= n_state;
            if (r_state == S_EVAL) begin
                r_range <= n_range;
            end
        end
    end

    // sample capture and staged result
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_s_axis_tvalid) begin
            r_sample <= i_s_axis_tdata;
        end
        if (r_state == S_EVAL) begin
            r_settled <= settle;
            r_used    <= r_range;
            if (!settle) begin
                r_res  <= '0;
                r_open <= 1'b0;
            end else if (nonpos) begin
                r_res  <= '1;
                r_open <= 1'b1;
            end
        end
        if ((r_state == S_DIV) && div_res.done) begin
            r_res  <= div_res.ovf ? '1 : div_res.quot;
            r_open <= div_res.ovf;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_settled <= r_settled;
            r_o_used    <= r_used;
            r_o_next    <= 4'b0001 << r_range;
            r_o_res     <= r_res;
            r_o_open    <= r_open;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {2'b00, r_o_res, r_o_next, r_o_used};
    assign o_m_axis_tuser  = {r_o_open, r_o_settled};

endmodule

@@ src/aro_checker.sv @@
// ----------------------------------------------------------------------------
// aro_checker
// port-level checks on the ohmmeter result stream and request handshake
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aro_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        o_s_axis_tready,
    input  logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [39:0] o_m_axis_tdata,
    input  logic [1:0]  o_m_axis_tuser
);

    // a pending result stays up until taken
    `ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid)

    // one sample in work at a time
    `ASSERT_NEXT(a_one_in_work, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)

    // switch drive selects exactly one resistor on every valid result
    `ASSERT_SAME(a_sel_onehot, o_m_axis_tvalid, $onehot(o_m_axis_tdata[5:2]))

    // open only on a settled result
    `ASSERT_SAME(a_open_settled, o_m_axis_tvalid && o_m_axis_tuser[1], o_m_axis_tuser[0])

    // a range step carries no resistance
    `ASSERT_SAME(a_step_zero, o_m_axis_tvalid && !o_m_axis_tuser[0],
                 o_m_axis_tdata[37:6] == 32'd0)

endmodule

bind autorange_ohmmeter aro_checker u_aro_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

@@ verif/autorange_ohmmeter_tb.sv @@
// ----------------------------------------------------------------------------
// autorange_ohmmeter_tb
// self-checking bench for the auto-ranging ohmmeter: adc samples go in on
// the sample stream, every result is checked field by field against an
// in-bench range tracker and fixed-point resistance calculation, over several
// register settings (defaults, window extremes, crossed thresholds, gain
// extremes) and several stall patterns on both streams
// ----------------------------------------------------------------------------
module autorange_ohmmeter_tb;

    typedef longint unsigned u64_t;

    // one sample request waiting for the driver
    typedef struct {
        logic [15:0] adc;
        bit          wait_idle;   // hold until every result is back
    } sample_req_t;

    // one result as the block reports it
    typedef struct packed {
        logic        settled;
        logic [1:0]  range_used;
        logic [3:0]  next_sel;
        logic [31:0] ohms;
        logic        open_flag;
    } reading_t;

    localparam int WDOG_LIMIT  = 3000;
    localparam int DRAIN_WAIT  = 100;
    localparam int GAIN_MAX    = 131071;
    localparam int SAMPLE_MAX  = 32767;

    // block ports
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata = '0;     // [15:0] adc_sample
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [39:0] o_m_axis_tdata;          // [1:0] range_used, [5:2] next_range_select,
                                          // [37:6] resistance_ohms, [39:38] zero
    logic [1:0]  o_m_axis_tuser;          // [0] settled, [1] open_flag
    logic        i_psel = 1'b0;
    logic        i_penable = 1'b0;
    logic        i_pwrite = 1'b0;
    logic [4:0]  i_paddr = '0;
    logic [31:0] i_pwdata = '0;
    logic [31:0] o_prdata;
    logic        o_pready;

    // bench state
    sample_req_t sample_q[$];
    reading_t    reading_q[$];
    bit          s_fire = 1'b0;
    int          idle_cycles = 0;
    int          mismatches = 0;
    int          send_gap_pct = 0;
    int          recv_stall_pct = 0;

    // model of the block registers and range
    logic [14:0] mdl_low_thr = aro_pkg::RST_LOW_THR;
    logic [14:0] mdl_high_thr = aro_pkg::RST_HIGH_THR;
    logic [16:0] mdl_gain[4] = '{aro_pkg::RST_GAIN0, aro_pkg::RST_GAIN1,
                                 aro_pkg::RST_GAIN2, aro_pkg::RST_GAIN3};
    logic [1:0]  mdl_range = 2'd0;

    autorange_ohmmeter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_psel          (i_psel),
        .i_penable       (i_penable),
        .i_pwrite        (i_pwrite),
        .i_paddr         (i_paddr),
        .i_pwdata        (i_pwdata),
        .o_prdata        (o_prdata),
        .o_pready        (o_pready)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // range decision and resistance for one accepted sample
    function automatic reading_t predict_reading(logic [15:0] adc);
        reading_t   r;
        int         raw;
        logic [1:0] used;
        bit         is_low;
        bit         is_high;
        u64_t       rref;
        u64_t       num;
        u64_t       den;
        u64_t       q;
        raw = int'($signed(adc));
        used = mdl_range;
        is_low = raw <= int'(mdl_low_thr);
        is_high = raw >= int'(mdl_high_thr);
        r = '0;
        r.range_used = used;
        r.settled = (!is_low && !is_high) || (is_low && used == 2'd3) ||
                    (is_high && used == 2'd0);
        if (r.settled) begin
            if (raw <= 0) begin
                r.ohms = '1;
                r.open_flag = 1'b1;
            end else begin
                case (used)
                    2'd0:    rref = 64'd1000;
                    2'd1:    rref = 64'd10000;
                    2'd2:    rref = 64'd100000;
                    default: rref = 64'd1000000;
                endcase
                num = rref * u64_t'(32768 - raw) * u64_t'(mdl_gain[used]);
                den = u64_t'(raw) << 16;
                // round half up
                q = (2 * num + den) / (2 * den);
                if (q > 64'hFFFF_FFFF) begin
                    r.ohms = '1;
                    r.open_flag = 1'b1;
                end else begin
                    r.ohms = q[31:0];
                end
            end
        end else if (is_low) begin
            mdl_range = used + 2'd1;
        end else begin
            mdl_range = used - 2'd1;
        end
        r.next_sel = 4'b0001 << mdl_range;
        return r;
    endfunction

    // compare one field, report the first few mismatches
    task automatic check_field(string what, u64_t want, u64_t got);
        if (want !== got) begin
            if (mismatches < 10)
                $display("mismatch %s: expected 0x%0h, got 0x%0h", what, want, got);
            mismatches++;
        end
    endtask

    // sample request driver and result ready, both on the falling edge
    always @(negedge i_clk) begin : drv
        sample_req_t req;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            if (!i_s_axis_tvalid || s_fire) begin
                if (sample_q.size() != 0 &&
                    !(sample_q[0].wait_idle && reading_q.size() != 0) &&
                    $urandom_range(99) >= send_gap_pct) begin
                    req = sample_q.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata <= req.adc;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: predict on sample accept, check on result accept, watchdog
    always @(posedge i_clk) begin : mon
        reading_t got;
        reading_t want;
        bit       in_fire;
        bit       out_fire;
        if (!i_rst_n) begin
            s_fire <= 1'b0;
            idle_cycles <= 0;
        end else begin
            in_fire = i_s_axis_tvalid && o_s_axis_tready;
            out_fire = o_m_axis_tvalid && i_m_axis_tready;
            s_fire <= in_fire;
            if (in_fire)
                reading_q.push_back(predict_reading(i_s_axis_tdata));
            if (out_fire) begin
                got.settled = o_m_axis_tuser[0];
                got.open_flag = o_m_axis_tuser[1];
                got.range_used = o_m_axis_tdata[1:0];
                got.next_sel = o_m_axis_tdata[5:2];
                got.ohms = o_m_axis_tdata[37:6];
                if (reading_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result: tdata 0x%0h tuser 0x%0h",
                                 o_m_axis_tdata, o_m_axis_tuser);
                    mismatches++;
                end else begin
                    want = reading_q.pop_front();
                    check_field("settled", want.settled, got.settled);
                    check_field("range_used", want.range_used, got.range_used);
                    check_field("next_range_select", want.next_sel, got.next_sel);
                    check_field("resistance_ohms", want.ohms, got.ohms);
                    check_field("open_flag", want.open_flag, got.open_flag);
                end
            end
            if (in_fire || out_fire) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // one register transfer: setup cycle then access cycle
    task automatic apb_xfer(input bit wr, input logic [2:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        @(negedge i_clk);
        i_psel <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite <= wr;
        i_paddr <= {idx, 2'b00};
        i_pwdata <= wdata;
        @(negedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        rdata = o_prdata;
        @(negedge i_clk);
        i_psel <= 1'b0;
        i_penable <= 1'b0;
    endtask

    // write a register, read it back and mirror it into the model
    task automatic set_reg(logic [2:0] idx, logic [31:0] val);
        logic [31:0] rd;
        apb_xfer(1'b1, idx, val, rd);
        apb_xfer(1'b0, idx, '0, rd);
        check_field("register readback", val, rd);
        case (idx)
            aro_pkg::REG_LOW_THR:  mdl_low_thr = val[14:0];
            aro_pkg::REG_HIGH_THR: mdl_high_thr = val[14:0];
            default:               mdl_gain[2'(idx - aro_pkg::REG_GAIN0)] = val[16:0];
        endcase
    endtask

    task automatic load_config(int lo, int hi, int g0, int g1, int g2, int g3);
        set_reg(aro_pkg::REG_LOW_THR, lo);
        set_reg(aro_pkg::REG_HIGH_THR, hi);
        set_reg(aro_pkg::REG_GAIN0, g0);
        set_reg(aro_pkg::REG_GAIN1, g1);
        set_reg(aro_pkg::REG_GAIN2, g2);
        set_reg(aro_pkg::REG_GAIN3, g3);
    endtask

    // wait until every request is taken and every result is back
    task automatic wait_drained();
        do @(negedge i_clk);
        while (sample_q.size() != 0 || i_s_axis_tvalid || reading_q.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    // random sample, biased toward the window, both sides and the edges
    function automatic logic [15:0] pick_sample();
        int lo;
        int hi;
        int sel;
        int v;
        lo = int'(mdl_low_thr);
        hi = int'(mdl_high_thr);
        sel = $urandom_range(99);
        if (sel < 40 && hi > lo + 1) begin
            v = $urandom_range(hi - 1, lo + 1);
        end else if (sel < 55) begin
            v = $urandom_range(lo, 0);
        end else if (sel < 70) begin
            v = $urandom_range(SAMPLE_MAX, hi);
        end else if (sel < 85) begin
            case ($urandom_range(10))
                0:       v = lo - 1;
                1:       v = lo;
                2:       v = lo + 1;
                3:       v = hi - 1;
                4:       v = hi;
                5:       v = hi + 1;
                6:       v = 0;
                7:       v = 1;
                8:       v = -1;
                9:       v = -32768;
                default: v = SAMPLE_MAX;
            endcase
        end else begin
            v = $urandom();
        end
        return v[15:0];
    endfunction

    // queue a batch of random samples, the one at hold_at (if any) held until idle
    task automatic run_random(int count, int hold_at);
        sample_req_t req;
        for (int k = 0; k < count; k++) begin
            req.adc = pick_sample();
            req.wait_idle = (k == hold_at);
            sample_q.push_back(req);
        end
        wait_drained();
    endtask

    // stimulus sequence
    initial begin : stim
        int lo;
        int hi;
        sample_req_t req;
        int dir_samples[26] = '{
            16000, 24000, 32767, 23999, 8001,       // settle on the 1k range
            8000, 0, -1,                            // step up to the 1M range
            -32768, 0, 1, 8000, 12000,              // open, overflow, settle on 1M
            24000, 32767, 30000,                    // step back down to 1k
            16384, 8000, 16384, 8000, 16384,        // settle on 1k, 10k and 100k
            0, 32767, -32768, 4000, 32767           // bounce at the top range
        };

        send_gap_pct = 34;
        recv_stall_pct = 70;
        i_rst_n = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed samples at the reset settings
        foreach (dir_samples[k]) begin
            req.adc = 16'(dir_samples[k]);
            req.wait_idle = 1'b0;
            sample_q.push_back(req);
        end
        wait_drained();

        // widest window, full gain
        load_config(0, SAMPLE_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX);
        run_random(88, 40);

        // fully crossed thresholds, zero gain
        load_config(SAMPLE_MAX, 0, 0, 0, 0, 0);
        run_random(88, -1);

        send_gap_pct = 70;
        recv_stall_pct = 34;

        // crossed thresholds, random gains
        load_config(20000, 10000, $urandom_range(GAIN_MAX), $urandom_range(GAIN_MAX),
                    $urandom_range(GAIN_MAX), $urandom_range(GAIN_MAX));
        run_random(88, -1);

        // narrow-edge window, random gains
        load_config(5000, 28000, $urandom_range(GAIN_MAX), $urandom_range(GAIN_MAX),
                    $urandom_range(GAIN_MAX), $urandom_range(GAIN_MAX));
        run_random(88, 30);

        send_gap_pct = 0;
        recv_stall_pct = 0;

        // back to the reset values
        load_config(int'(aro_pkg::RST_LOW_THR), int'(aro_pkg::RST_HIGH_THR),
                    int'(aro_pkg::RST_GAIN0), int'(aro_pkg::RST_GAIN1),
                    int'(aro_pkg::RST_GAIN2), int'(aro_pkg::RST_GAIN3));
        run_random(88, -1);

        // random ordered window, random gains
        lo = $urandom_range(16000, 0);
        hi = $urandom_range(SAMPLE_MAX, lo + 2);
        load_config(lo, hi, $urandom_range(GAIN_MAX), $urandom_range(GAIN_MAX),
                    $urandom_range(GAIN_MAX), $urandom_range(GAIN_MAX));
        run_random(88, -1);

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (reading_q.size() != 0)
            mismatches++;
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
